// File: sv/tlsf_pkg.sv
// Shared types, constants and codes of the TLSF free-list manager.
package tlsf_pkg;

    localparam int FIRST_CLASSES_DEF  = 24;
    localparam int SECOND_CLASSES_DEF = 32;
    localparam int BLOCK_COUNT_DEF    = 256;

    localparam int ACT_W     = 2;
    localparam int FL_W      = 5;
    localparam int SL_W      = 5;
    localparam int ID_W      = 8;
    localparam int ST_W      = 2;
    localparam int MAP_W     = 32;
    localparam int MAP_IDX_W = 5;
    localparam int POS_W     = 6;
    localparam int HEAD_AW   = 10;
    localparam int LINK_AW   = 16;
    localparam int CBM_AW    = 5;

    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] found_block;
        logic [FL_W-1:0] found_first;
        logic [SL_W-1:0] found_second;
        logic [ST_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic               cbm_we;
        logic [CBM_AW-1:0]  cbm_waddr;
        logic [MAP_W-1:0]   cbm_wdata;
        logic [CBM_AW-1:0]  cbm_raddr;
        logic               head_we;
        logic [HEAD_AW-1:0] head_waddr;
        logic [ID_W-1:0]    head_wdata;
        logic [HEAD_AW-1:0] head_raddr;
        logic               next_we;
        logic [LINK_AW-1:0] next_waddr;
        logic [ID_W-1:0]    next_wdata;
        logic [LINK_AW-1:0] next_raddr;
        logic               prev_we;
        logic [LINK_AW-1:0] prev_waddr;
        logic [ID_W-1:0]    prev_wdata;
        logic [LINK_AW-1:0] prev_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [MAP_W-1:0] cbm;
        logic [ID_W-1:0]  head;
        logic [ID_W-1:0]  next;
        logic [ID_W-1:0]  prev;
    } t_mem_rd;

endpackage

// File: sv/tlsf_ifs.sv
// Valid/ready channel interfaces for request and response words.
interface tlsf_req_if;
    logic                         valid;
    logic                         ready;
    logic [tlsf_pkg::ACT_W-1:0]   action;
    logic [tlsf_pkg::FL_W-1:0]    major_class;
    logic [tlsf_pkg::SL_W-1:0]    minor_class;
    logic [tlsf_pkg::ID_W-1:0]    block_id;

    modport source (output valid, action, major_class, minor_class, block_id,
                    input ready);
    modport sink (input valid, action, major_class, minor_class, block_id,
                  output ready);
endinterface

interface tlsf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [tlsf_pkg::ID_W-1:0]    found_block;
    logic [tlsf_pkg::FL_W-1:0]    found_first;
    logic [tlsf_pkg::SL_W-1:0]    found_second;
    logic [tlsf_pkg::ST_W-1:0]    status;

    modport source (output valid, found, found_block, found_first, found_second, status,
                    input ready);
    modport sink (input valid, found, found_block, found_first, found_second, status,
                  output ready);
endinterface

// File: sv/tlsf_free_list_manager.sv
// Top level of the TLSF two-level segregated-fit free-list manager.
// Takes one request word at a time and returns one response word per request. A search that
// falls back to a higher first-level class passes through more states than a direct search,
// an insert or a remove, and a rejected request goes straight to its response. This
// sequencing comes from the head, link and bitmap memories with one registered read port
// each and the one find-first-set unit that the sequencer reuses for the second-level and
// first-level lookups. A finished response waits in an output register, so the next request
// is taken while it is still pending; a request that finishes while that register still
// holds an unaccepted word stalls until the word is taken. After reset a clearing pass writes
// every memory entry, and ready stays low until the cycle after the pass ends.
module tlsf_free_list_manager #(
    parameter int FIRST_CLASSES  = tlsf_pkg::FIRST_CLASSES_DEF,
    parameter int SECOND_CLASSES = tlsf_pkg::SECOND_CLASSES_DEF,
    parameter int BLOCK_COUNT    = tlsf_pkg::BLOCK_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlsf_req_if.sink   i_req,
    tlsf_rsp_if.source o_rsp
);
    localparam int FL_W      = tlsf_pkg::FL_W;
    localparam int SL_W      = tlsf_pkg::SL_W;
    localparam int ID_W      = tlsf_pkg::ID_W;
    localparam int MAP_W     = tlsf_pkg::MAP_W;
    localparam int MAP_IDX_W = tlsf_pkg::MAP_IDX_W;
    localparam int POS_W     = tlsf_pkg::POS_W;
    localparam int HEAD_AW   = tlsf_pkg::HEAD_AW;
    localparam int LINK_AW   = tlsf_pkg::LINK_AW;
    localparam int CBM_AW    = tlsf_pkg::CBM_AW;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_S_MAP   = 11'b000_0000_0100,
        S_S_TOP   = 11'b000_0000_1000,
        S_S_MAP2  = 11'b000_0001_0000,
        S_S_HEAD  = 11'b000_0010_0000,
        S_I_LINK  = 11'b000_0100_0000,
        S_I_PREV  = 11'b000_1000_0000,
        S_R_PREV  = 11'b001_0000_0000,
        S_R_NEXT  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state                  r_state;
    logic [FL_W-1:0]         r_fl;
    logic [SL_W-1:0]         r_sl;
    logic [ID_W-1:0]         r_blk;
    logic [HEAD_AW-1:0]      r_slot;
    logic [FL_W-1:0]         r_f;
    logic [ID_W-1:0]         r_cur;
    logic [ID_W-1:0]         r_prv;
    logic [ID_W-1:0]         r_nxt;
    logic                    r_hit;
    logic [MAP_W-1:0]        r_cbm;
    logic [FIRST_CLASSES-1:0] r_top;
    tlsf_pkg::t_rsp          r_res;
    tlsf_pkg::t_rsp          r_out;
    logic                    r_out_valid;

    tlsf_pkg::t_mem_req      c_mem;
    tlsf_pkg::t_mem_rd       c_rd;
    logic                    c_store_ready;
    logic [MAP_W-1:0]        c_ffs_vec;
    logic [POS_W-1:0]        c_ffs_from;
    logic                    c_ffs_any;
    logic [MAP_IDX_W-1:0]    c_ffs_idx;
    logic [HEAD_AW-1:0]      c_in_slot;
    logic [HEAD_AW-1:0]      c_srch_slot;
    logic [MAP_W-1:0]        c_cbm_clr;
    logic                    c_bad;
    logic                    c_is_search;
    logic                    c_load;
    tlsf_pkg::t_rsp          c_init_rsp;

    tlsf_store #(
        .FIRST_CLASSES  (FIRST_CLASSES),
        .SECOND_CLASSES (SECOND_CLASSES),
        .BLOCK_COUNT    (BLOCK_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (c_mem),
        .o_mem   (c_rd),
        .o_ready (c_store_ready)
    );

    tlsf_ffs u_ffs (
        .i_vec  (c_ffs_vec),
        .i_from (c_ffs_from),
        .o_any  (c_ffs_any),
        .o_idx  (c_ffs_idx)
    );

    assign c_in_slot   = HEAD_AW'(32'(i_req.major_class) * SECOND_CLASSES
                                  + 32'(i_req.minor_class));
    assign c_srch_slot = HEAD_AW'(32'(r_f) * SECOND_CLASSES + 32'(c_ffs_idx));
    assign c_cbm_clr   = r_cbm & ~(MAP_W'(1) << r_sl);
    assign c_is_search = (i_req.action == tlsf_pkg::ACT_SEARCH);
    assign c_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        c_bad = (i_req.action != tlsf_pkg::ACT_SEARCH
                 && i_req.action != tlsf_pkg::ACT_INSERT
                 && i_req.action != tlsf_pkg::ACT_REMOVE)
             || (32'(i_req.major_class) >= FIRST_CLASSES)
             || (32'(i_req.minor_class) >= SECOND_CLASSES)
             || (!c_is_search && (i_req.block_id == '0
                                  || 32'(i_req.block_id) >= BLOCK_COUNT));
    end

    always_comb begin
        c_init_rsp        = '0;
        c_init_rsp.status = c_bad ? tlsf_pkg::ST_BAD : tlsf_pkg::ST_OK;
    end

    // shared lookup unit: second-level map from the request, then first-level fallback
    always_comb begin
        c_ffs_vec  = c_rd.cbm;
        c_ffs_from = '0;
        unique case (r_state)
            S_S_MAP:  c_ffs_from = POS_W'(r_sl);
            S_S_TOP: begin
                c_ffs_vec  = MAP_W'(r_top);
                c_ffs_from = POS_W'(r_fl) + POS_W'(1);
            end
            default:  c_ffs_from = '0;
        endcase
    end

    always_comb begin
        c_mem = '0;
        unique case (r_state)
            S_IDLE: begin
                c_mem.cbm_raddr  = CBM_AW'(i_req.major_class);
                c_mem.head_raddr = c_in_slot;
                c_mem.next_raddr = LINK_AW'(i_req.block_id);
                c_mem.prev_raddr = LINK_AW'(i_req.block_id);
            end
            S_S_MAP, S_S_MAP2: begin
                c_mem.head_raddr = c_srch_slot;
            end
            S_S_TOP: begin
                c_mem.cbm_raddr = CBM_AW'(c_ffs_idx);
            end
            S_I_LINK: begin
                c_mem.next_we    = 1'b1;
                c_mem.next_waddr = LINK_AW'(r_blk);
                c_mem.next_wdata = c_rd.head;
                c_mem.prev_we    = 1'b1;
                c_mem.prev_waddr = LINK_AW'(r_blk);
                c_mem.prev_wdata = '0;
                c_mem.head_we    = 1'b1;
                c_mem.head_waddr = r_slot;
                c_mem.head_wdata = r_blk;
                c_mem.cbm_we     = 1'b1;
                c_mem.cbm_waddr  = CBM_AW'(r_fl);
                c_mem.cbm_wdata  = c_rd.cbm | (MAP_W'(1) << r_sl);
            end
            S_I_PREV: begin
                // old head points back at the new one
                c_mem.prev_we    = 1'b1;
                c_mem.prev_waddr = LINK_AW'(r_cur);
                c_mem.prev_wdata = r_blk;
            end
            S_R_PREV: begin
                c_mem.prev_we    = 1'b1;
                c_mem.prev_waddr = LINK_AW'(c_rd.next);
                c_mem.prev_wdata = c_rd.prev;
            end
            S_R_NEXT: begin
                c_mem.next_we    = 1'b1;
                c_mem.next_waddr = LINK_AW'(r_prv);
                c_mem.next_wdata = r_nxt;
                c_mem.head_we    = r_hit;
                c_mem.head_waddr = r_slot;
                c_mem.head_wdata = r_nxt;
                c_mem.cbm_we     = r_hit && (r_nxt == '0);
                c_mem.cbm_waddr  = CBM_AW'(r_fl);
                c_mem.cbm_wdata  = c_cbm_clr;
            end
            default: c_mem = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_top       <= '0;
        end else begin
            if (c_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (c_store_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_fl   <= i_req.major_class;
                        r_sl   <= i_req.minor_class;
                        r_blk  <= i_req.block_id;
                        r_slot <= c_in_slot;
                        r_f    <= i_req.major_class;
                        r_res  <= c_init_rsp;
                        priority if (c_bad) begin
                            r_state <= S_DONE;
                        end else if (c_is_search) begin
                            r_state <= S_S_MAP;
                        end else if (i_req.action == tlsf_pkg::ACT_INSERT) begin
                            r_state <= S_I_LINK;
                        end else begin
                            r_state <= S_R_PREV;
                        end
                    end
                end
                S_S_MAP: begin
                    if (c_ffs_any) begin
                        r_res.found_second <= SL_W'(c_ffs_idx);
                        r_state            <= S_S_HEAD;
                    end else begin
                        r_state <= S_S_TOP;
                    end
                end
                S_S_TOP: begin
                    if (c_ffs_any) begin
                        r_f     <= FL_W'(c_ffs_idx);
                        r_state <= S_S_MAP2;
                    end else begin
                        r_res.status <= tlsf_pkg::ST_NONE;
                        r_state      <= S_DONE;
                    end
                end
                S_S_MAP2: begin
                    if (c_ffs_any) begin
                        r_res.found_second <= SL_W'(c_ffs_idx);
                        r_state            <= S_S_HEAD;
                    end else begin
                        r_res.status <= tlsf_pkg::ST_NONE;
                        r_state      <= S_DONE;
                    end
                end
                S_S_HEAD: begin
                    r_res.found       <= 1'b1;
                    r_res.found_block <= c_rd.head;
                    r_res.found_first <= r_f;
                    r_state           <= S_DONE;
                end
                S_I_LINK: begin
                    r_cur   <= c_rd.head;
                    r_top   <= r_top | (FIRST_CLASSES'(1) << r_fl);
                    r_state <= S_I_PREV;
                end
                S_I_PREV: begin
                    r_state <= S_DONE;
                end
                S_R_PREV: begin
                    r_prv   <= c_rd.prev;
                    r_nxt   <= c_rd.next;
                    r_hit   <= (c_rd.head == r_blk);
                    r_cbm   <= c_rd.cbm;
                    r_state <= S_R_NEXT;
                end
                S_R_NEXT: begin
                    // list emptied: drop the class bit, and the first-level bit once no class bit is left
                    if (r_hit && r_nxt == '0 && c_cbm_clr == '0) begin
                        r_top <= r_top & ~(FIRST_CLASSES'(1) << r_fl);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (c_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out.found;
    assign o_rsp.found_block  = r_out.found_block;
    assign o_rsp.found_first  = r_out.found_first;
    assign o_rsp.found_second = r_out.found_second;
    assign o_rsp.status       = r_out.status;

endmodule

// File: sv/tlsf_ffs.sv
// Shared masked find-first-set unit over one bitmap word.
module tlsf_ffs (
    input  logic [tlsf_pkg::MAP_W-1:0]     i_vec,
    input  logic [tlsf_pkg::POS_W-1:0]     i_from,
    output logic                           o_any,
    output logic [tlsf_pkg::MAP_IDX_W-1:0] o_idx
);
    localparam int MAP_W     = tlsf_pkg::MAP_W;
    localparam int POS_W     = tlsf_pkg::POS_W;
    localparam int MAP_IDX_W = tlsf_pkg::MAP_IDX_W;

    logic [MAP_W-1:0] c_mask;
    logic [MAP_W-1:0] c_sel;
    logic [MAP_W-1:0] c_low;

    always_comb begin
        // positions at or above i_from; a start of 32 or more leaves nothing
        c_mask = i_from[POS_W-1] ? '0 : ({MAP_W{1'b1}} << i_from[POS_W-2:0]);
        c_sel  = i_vec & c_mask;
        c_low  = c_sel & (~c_sel + MAP_W'(1));
        o_any  = |c_sel;
        o_idx  = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (c_low[i]) begin
                o_idx = o_idx | MAP_IDX_W'(i);
            end
        end
    end

endmodule

// File: sv/tlsf_store.sv
// Bitmap, head and link memories with registered reads and a clearing pass after reset.
module tlsf_store #(
    parameter int FIRST_CLASSES  = tlsf_pkg::FIRST_CLASSES_DEF,
    parameter int SECOND_CLASSES = tlsf_pkg::SECOND_CLASSES_DEF,
    parameter int BLOCK_COUNT    = tlsf_pkg::BLOCK_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlsf_pkg::t_mem_req i_mem,
    output tlsf_pkg::t_mem_rd  o_mem,
    output logic               o_ready
);
    localparam int ID_W       = tlsf_pkg::ID_W;
    localparam int MAP_W      = tlsf_pkg::MAP_W;
    localparam int HEAD_DEPTH = FIRST_CLASSES * SECOND_CLASSES;
    localparam int CBM_A      = $clog2(FIRST_CLASSES);
    localparam int HEAD_A     = $clog2(HEAD_DEPTH);
    localparam int LINK_A     = $clog2(BLOCK_COUNT);
    localparam int CLR_DEPTH  = (HEAD_DEPTH > BLOCK_COUNT) ? HEAD_DEPTH : BLOCK_COUNT;
    localparam int CLR_A      = $clog2(CLR_DEPTH);
    localparam int CLR_EW     = CLR_A + 1;

    logic [SECOND_CLASSES-1:0] r_cbm_mem  [FIRST_CLASSES];
    logic [ID_W-1:0]           r_head_mem [HEAD_DEPTH];
    logic [ID_W-1:0]           r_next_mem [BLOCK_COUNT];
    logic [ID_W-1:0]           r_prev_mem [BLOCK_COUNT];

    logic [SECOND_CLASSES-1:0] r_cbm_q;
    logic [ID_W-1:0]           r_head_q;
    logic [ID_W-1:0]           r_next_q;
    logic [ID_W-1:0]           r_prev_q;

    logic [CLR_A-1:0]  r_clr_idx;
    logic              r_clr_busy;
    logic [CLR_EW-1:0] c_clr_ext;

    assign c_clr_ext = {1'b0, r_clr_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + CLR_A'(1);
            if (r_clr_idx == CLR_A'(CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (c_clr_ext < CLR_EW'(FIRST_CLASSES)) begin
                r_cbm_mem[r_clr_idx[CBM_A-1:0]] <= '0;
            end
        end else if (i_mem.cbm_we) begin
            r_cbm_mem[i_mem.cbm_waddr[CBM_A-1:0]] <= i_mem.cbm_wdata[SECOND_CLASSES-1:0];
        end
        r_cbm_q <= r_cbm_mem[i_mem.cbm_raddr[CBM_A-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (c_clr_ext < CLR_EW'(HEAD_DEPTH)) begin
                r_head_mem[r_clr_idx[HEAD_A-1:0]] <= '0;
            end
        end else if (i_mem.head_we) begin
            r_head_mem[i_mem.head_waddr[HEAD_A-1:0]] <= i_mem.head_wdata;
        end
        r_head_q <= r_head_mem[i_mem.head_raddr[HEAD_A-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (c_clr_ext < CLR_EW'(BLOCK_COUNT)) begin
                r_next_mem[r_clr_idx[LINK_A-1:0]] <= '0;
            end
        end else if (i_mem.next_we) begin
            r_next_mem[i_mem.next_waddr[LINK_A-1:0]] <= i_mem.next_wdata;
        end
        r_next_q <= r_next_mem[i_mem.next_raddr[LINK_A-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (c_clr_ext < CLR_EW'(BLOCK_COUNT)) begin
                r_prev_mem[r_clr_idx[LINK_A-1:0]] <= '0;
            end
        end else if (i_mem.prev_we) begin
            r_prev_mem[i_mem.prev_waddr[LINK_A-1:0]] <= i_mem.prev_wdata;
        end
        r_prev_q <= r_prev_mem[i_mem.prev_raddr[LINK_A-1:0]];
    end

    assign o_mem.cbm  = MAP_W'(r_cbm_q);
    assign o_mem.head = r_head_q;
    assign o_mem.next = r_next_q;
    assign o_mem.prev = r_prev_q;
    assign o_ready    = !r_clr_busy;

endmodule

// File: sv/tlsf_checker.sv
// Port-level checker for the TLSF free-list manager, bound to the top level.
module tlsf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_found,
    input logic [tlsf_pkg::ID_W-1:0]   i_found_block,
    input logic [tlsf_pkg::FL_W-1:0]   i_found_first,
    input logic [tlsf_pkg::SL_W-1:0]   i_found_second,
    input logic [tlsf_pkg::ST_W-1:0]   i_status
);
    // words accepted in minus words delivered
    logic [1:0] r_outst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 2'(i_req_valid && i_req_ready)
                               - 2'(i_rsp_valid && i_rsp_ready);
        end
    end

    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outst != 2'd0)
        else $error("response word without an accepted request word");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_found)
            && $stable(i_found_block) && $stable(i_found_first)
            && $stable(i_found_second) && $stable(i_status))
        else $error("stalled response word changed");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != tlsf_pkg::ST_OK |-> !i_found
            && i_found_block == '0 && i_found_first == '0 && i_found_second == '0)
        else $error("failed request reports a class");

    a_found_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found |-> i_status == tlsf_pkg::ST_OK && i_found_block != '0)
        else $error("found class has sentinel head or bad status");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken before memories are cleared");

endmodule

bind tlsf_free_list_manager tlsf_checker u_tlsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_found        (o_rsp.found),
    .i_found_block  (o_rsp.found_block),
    .i_found_first  (o_rsp.found_first),
    .i_found_second (o_rsp.found_second),
    .i_status       (o_rsp.status)
);
